// File: sv/sspc_pkg.sv
// Package: request/response types and codes for the servo status packet checker.
`timescale 1ns / 1ps
package sspc_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hFF;
	localparam logic [7:0] NO_ERROR  = 8'h00;
	localparam logic [2:0] SHORT_LAST = 3'd5;
	localparam logic [2:0] LONG_LAST  = 3'd7;
	localparam logic [2:0] ID_INDEX   = 3'd2;
	localparam logic [2:0] ERR_INDEX  = 3'd4;
	localparam logic [2:0] POSL_INDEX = 3'd5;
	localparam logic [2:0] POSH_INDEX = 3'd6;

	typedef enum logic [1:0] {
		CMD_START    = 2'd0,
		CMD_BYTE     = 2'd1,
		CMD_TIMEOUT  = 2'd2,
		CMD_LINK_ERR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TIMEOUT  = 3'd1,
		ST_RXERR    = 3'd2,
		ST_HEADER   = 3'd3,
		ST_ID       = 3'd4,
		ST_CHECKSUM = 3'd5,
		ST_SERVO    = 3'd6
	} status_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] reply_id;
		logic       position_reply;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] position;
	} rsp_t;

endpackage

// File: sv/sspc_in_stage.sv
// Input register stage holding one accepted request.
`timescale 1ns / 1ps
module sspc_in_stage import sspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	input  logic advance,
	output logic valid_s1,
	output req_t req_s1
);

	logic valid_s1_r;

	assign req_ready = !valid_s1_r || advance;
	assign valid_s1  = valid_s1_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (req_ready) begin
			valid_s1_r <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

endmodule

// File: sv/sspc_tracker.sv
// Transaction state and per-byte checks; forms the response for a closing request.
`timescale 1ns / 1ps
module sspc_tracker import sspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req_s1,
	output logic emit,
	output rsp_t result
);

	logic       busy_q;
	logic       long_reply_q;
	logic [7:0] want_id_q;
	logic [2:0] byte_index_q;
	logic [7:0] running_sum_q;
	logic       header_bad_q;
	logic       id_bad_q;
	logic       error_seen_q;
	logic [7:0] pos_low_q;
	logic [7:0] pos_high_q;

	logic       busy_d;
	logic       long_reply_d;
	logic [7:0] want_id_d;
	logic [2:0] byte_index_d;
	logic [7:0] running_sum_d;
	logic       header_bad_d;
	logic       id_bad_d;
	logic       error_seen_d;
	logic [7:0] pos_low_d;
	logic [7:0] pos_high_d;
	logic [2:0] last_index;
	logic [7:0] b;

	assign b          = req_s1.rx_byte;
	assign last_index = long_reply_q ? LONG_LAST : SHORT_LAST;

	always_comb begin
		busy_d        = busy_q;
		long_reply_d  = long_reply_q;
		want_id_d     = want_id_q;
		byte_index_d  = byte_index_q;
		running_sum_d = running_sum_q;
		header_bad_d  = header_bad_q;
		id_bad_d      = id_bad_q;
		error_seen_d  = error_seen_q;
		pos_low_d     = pos_low_q;
		pos_high_d    = pos_high_q;
		emit          = 1'b0;
		result.status   = ST_OK;
		result.position = 16'd0;
		case (req_s1.command)
			CMD_START: begin
				busy_d        = 1'b1;
				long_reply_d  = req_s1.position_reply;
				want_id_d     = req_s1.reply_id;
				byte_index_d  = 3'd0;
				running_sum_d = 8'd0;
				header_bad_d  = 1'b0;
				id_bad_d      = 1'b0;
				error_seen_d  = 1'b0;
				pos_low_d     = 8'd0;
				pos_high_d    = 8'd0;
			end
			CMD_TIMEOUT: begin
				if (busy_q) begin
					emit          = 1'b1;
					result.status = ST_TIMEOUT;
					busy_d        = 1'b0;
				end
			end
			CMD_LINK_ERR: begin
				if (busy_q) begin
					emit          = 1'b1;
					result.status = ST_RXERR;
					busy_d        = 1'b0;
				end
			end
			CMD_BYTE: begin
				if (busy_q) begin
					if (byte_index_q < 3'd2) begin
						if (b != HDR_BYTE) begin
							header_bad_d = 1'b1;
						end
						byte_index_d = byte_index_q + 3'd1;
					end else if (byte_index_q < last_index) begin
						if (byte_index_q == ID_INDEX && b != want_id_q) begin
							id_bad_d = 1'b1;
						end
						if (byte_index_q == ERR_INDEX && b != NO_ERROR) begin
							error_seen_d = 1'b1;
						end
						if (byte_index_q == POSL_INDEX) begin
							pos_low_d = b;
						end
						if (byte_index_q == POSH_INDEX) begin
							pos_high_d = b;
						end
						running_sum_d = running_sum_q + b;
						byte_index_d  = byte_index_q + 3'd1;
					end else begin
						emit = 1'b1;
						if (header_bad_q) begin
							result.status = ST_HEADER;
						end else if (id_bad_q) begin
							result.status = ST_ID;
						end else if (b != ~running_sum_q) begin
							result.status = ST_CHECKSUM;
						end else if (error_seen_q) begin
							result.status = ST_SERVO;
						end else begin
							result.status = ST_OK;
						end
						if (result.status == ST_OK && long_reply_q) begin
							result.position = {pos_high_q, pos_low_q};
						end
						byte_index_d = 3'd0;
						busy_d       = 1'b0;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			long_reply_q  <= 1'b0;
			want_id_q     <= 8'd0;
			byte_index_q  <= 3'd0;
			running_sum_q <= 8'd0;
			header_bad_q  <= 1'b0;
			id_bad_q      <= 1'b0;
			error_seen_q  <= 1'b0;
			pos_low_q     <= 8'd0;
			pos_high_q    <= 8'd0;
		end else if (fire) begin
			busy_q        <= busy_d;
			long_reply_q  <= long_reply_d;
			want_id_q     <= want_id_d;
			byte_index_q  <= byte_index_d;
			running_sum_q <= running_sum_d;
			header_bad_q  <= header_bad_d;
			id_bad_q      <= id_bad_d;
			error_seen_q  <= error_seen_d;
			pos_low_q     <= pos_low_d;
			pos_high_q    <= pos_high_d;
		end
	end

	a_emit_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> busy_q)
		else $error("response formed with no open transaction");

	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> !busy_q)
		else $error("transaction still open after response");

	a_start_opens: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_s1.command == CMD_START |=> busy_q && byte_index_q == 3'd0
			&& running_sum_q == 8'd0)
		else $error("start did not open a clean transaction");

	a_last_byte_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && req_s1.command == CMD_BYTE && byte_index_q == last_index |-> emit)
		else $error("last reply byte gave no response");

	a_pos_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		emit && result.position != 16'd0 |-> result.status == ST_OK && long_reply_q)
		else $error("position given on a failed or short reply");

endmodule

// File: sv/sspc_out_stage.sv
// Response register toward the receiver.
`timescale 1ns / 1ps
module sspc_out_stage import sspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rsp_t result,
	output logic free,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign free      = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= result;
		end
	end

endmodule

// File: sv/servo_status_packet_checker.sv
// Top level: servo status reply checker.
// Requests arrive on req (valid/ready): a start opens a transaction with the
// expected id and reply kind, then reply bytes follow one per request;
// timeout and link-error requests close an open transaction.
// One response (status, position) leaves on rsp (valid/ready) per closed
// transaction; starts, bytes before the last, and requests while idle give none.
// A closing request is registered in the input register when accepted, and
// its response is registered in the response register when it advances,
// raising rsp_valid. One request per cycle, unless a response must form
// while the response register is full; the state update sits between them.
// The response register lets a new request enter while an earlier response
// waits; when rsp_ready stays low and a further response is ready to form,
// the input register holds and req_ready drops until the response is taken.
// Reset (arst_n low) closes any transaction and empties both registers.
`timescale 1ns / 1ps
module servo_status_packet_checker import sspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic valid_s1;
	req_t req_s1;
	logic emit;
	rsp_t result;
	logic free;
	logic advance;

	assign advance = valid_s1 && (!emit || free);

	sspc_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1)
	);

	sspc_tracker u_trk (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req_s1 (req_s1),
		.emit   (emit),
		.result (result)
	);

	sspc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result    (result),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: test/sspc_reply_monitor.sv
// Reply monitor: tracks requests, predicts status replies and checks the response channel.
`timescale 1ns / 1ps
module sspc_reply_monitor import sspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding
);

	logic       open_txn;
	logic       long_kind;
	logic [7:0] id_wanted;
	logic [2:0] idx;
	logic [7:0] sum;
	logic       hdr_fail;
	logic       id_fail;
	logic       servo_fail;
	logic [7:0] pos_lo;
	logic [7:0] pos_hi;
	rsp_t       expected_replies[$];
	rsp_t       head;
	int         fail_count;

	task automatic clear_reply_state();
		idx        = '0;
		sum        = '0;
		hdr_fail   = 1'b0;
		id_fail    = 1'b0;
		servo_fail = 1'b0;
		pos_lo     = '0;
		pos_hi     = '0;
	endtask

	task automatic track_request(input req_t r);
		logic [2:0] last_idx;
		rsp_t       reply;
		reply.status   = ST_OK;
		reply.position = '0;
		case (r.command)
			CMD_START: begin
				clear_reply_state();
				open_txn  = 1'b1;
				id_wanted = r.reply_id;
				long_kind = r.position_reply;
			end
			CMD_TIMEOUT: begin
				if (open_txn) begin
					reply.status = ST_TIMEOUT;
					expected_replies.push_back(reply);
					open_txn = 1'b0;
				end
			end
			CMD_LINK_ERR: begin
				if (open_txn) begin
					reply.status = ST_RXERR;
					expected_replies.push_back(reply);
					open_txn = 1'b0;
				end
			end
			default: begin
				if (open_txn) begin
					last_idx = long_kind ? LONG_LAST : SHORT_LAST;
					if (idx < ID_INDEX) begin
						if (r.rx_byte != HDR_BYTE)
							hdr_fail = 1'b1;
						idx++;
					end else if (idx < last_idx) begin
						if (idx == ID_INDEX && r.rx_byte != id_wanted)
							id_fail = 1'b1;
						if (idx == ERR_INDEX && r.rx_byte != NO_ERROR)
							servo_fail = 1'b1;
						if (idx == POSL_INDEX)
							pos_lo = r.rx_byte;
						if (idx == POSH_INDEX)
							pos_hi = r.rx_byte;
						sum = sum + r.rx_byte;
						idx++;
					end else begin
						if (hdr_fail)
							reply.status = ST_HEADER;
						else if (id_fail)
							reply.status = ST_ID;
						else if (r.rx_byte != ~sum)
							reply.status = ST_CHECKSUM;
						else if (servo_fail)
							reply.status = ST_SERVO;
						if (reply.status == ST_OK && long_kind)
							reply.position = {pos_hi, pos_lo};
						idx      = '0;
						open_txn = 1'b0;
						expected_replies.push_back(reply);
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_txn   = 1'b0;
			long_kind  = 1'b0;
			id_wanted  = '0;
			clear_reply_state();
			expected_replies.delete();
			fail_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected reply: status=%0d position=%0h", $time,
						rsp.status, rsp.position);
					fail_count++;
				end else begin
					head = expected_replies.pop_front();
					if (rsp.status !== head.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d", $time,
							head.status, rsp.status);
						fail_count++;
					end
					if (rsp.position !== head.position) begin
						$display("%0t: position mismatch: expected %0h actual %0h", $time,
							head.position, rsp.position);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready)
				track_request(req);
			mismatches  <= fail_count;
			outstanding <= expected_replies.size();
		end
	end

endmodule

// File: test/tb_top.sv
// Testbench top: drives servo reply byte streams into the checker and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
	import sspc_pkg::*;

	localparam int ITEM_TARGET = 1750;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		F_NONE,
		F_HEADER,
		F_ID,
		F_CHECKSUM,
		F_SERVO,
		F_TIMEOUT,
		F_LINK,
		F_RESTART,
		F_GARBLE
	} fault_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;
	int   cycles      = 0;
	int   items_sent  = 0;
	int   ignored     = 0;
	logic calm        = 1'b0;
	logic txn_open    = 1'b0;

	always #4 clk = ~clk;

	servo_status_packet_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sspc_reply_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		rsp_ready <= calm || ($urandom_range(99) >= 7);
	end

	task automatic issue(input cmd_t c, input logic [7:0] id, input logic kind,
			input logic [7:0] b);
		req_t r;
		r.command        = c;
		r.reply_id       = id;
		r.position_reply = kind;
		r.rx_byte        = b;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		items_sent++;
		if (!calm) begin
			while ($urandom_range(99) < 7) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		issue(CMD_BYTE, 8'($urandom), 1'($urandom), b);
	endtask

	task automatic send_idle_noise();
		cmd_t c;
		c = cmd_t'($urandom_range(3, 1));
		issue(c, 8'($urandom), 1'($urandom), 8'($urandom));
		ignored++;
	endtask

	task automatic send_reply(input logic [7:0] id, input logic kind, input logic [15:0] pos,
			input fault_t fault);
		logic [7:0] bytes[8];
		logic [7:0] chk;
		int         n;
		int         cut;
		n        = kind ? 8 : 6;
		bytes[0] = HDR_BYTE;
		bytes[1] = HDR_BYTE;
		bytes[2] = id;
		bytes[3] = kind ? 8'd4 : 8'd2;
		bytes[4] = NO_ERROR;
		bytes[5] = pos[7:0];
		bytes[6] = pos[15:8];
		bytes[7] = '0;
		case (fault)
			F_HEADER: bytes[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
			F_ID:     bytes[2] ^= 8'($urandom_range(255, 1));
			F_SERVO:  bytes[4] = 8'($urandom_range(255, 1));
			F_GARBLE: begin
				for (int i = 0; i < 8; i++)
					bytes[i] = ($urandom_range(3) == 0) ? bytes[i] : 8'($urandom);
			end
			default: ;
		endcase
		chk = '0;
		for (int i = 2; i < n - 1; i++)
			chk = chk + bytes[i];
		bytes[n - 1] = ~chk;
		if (fault == F_CHECKSUM)
			bytes[n - 1] ^= 8'($urandom_range(255, 1));
		if (fault == F_GARBLE && $urandom_range(1))
			bytes[n - 1] = 8'($urandom);
		cut = (fault == F_TIMEOUT || fault == F_LINK || fault == F_RESTART) ?
			int'($urandom_range(n - 1)) : n;
		issue(CMD_START, id, kind, 8'($urandom));
		for (int i = 0; i < cut; i++)
			send_byte(bytes[i]);
		txn_open = 1'b0;
		case (fault)
			F_TIMEOUT: issue(CMD_TIMEOUT, 8'($urandom), 1'($urandom), 8'($urandom));
			F_LINK:    issue(CMD_LINK_ERR, 8'($urandom), 1'($urandom), 8'($urandom));
			F_RESTART: txn_open = 1'b1;
			default: ;
		endcase
	endtask

	task automatic random_reply();
		logic [7:0]  id;
		logic [15:0] pos;
		int          pick;
		fault_t      fault;
		if (!txn_open && $urandom_range(99) < 6)
			send_idle_noise();
		pick = $urandom_range(9);
		id   = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
		pick = $urandom_range(9);
		pos  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 55)
			fault = F_NONE;
		else if (pick < 61)
			fault = F_HEADER;
		else if (pick < 67)
			fault = F_ID;
		else if (pick < 73)
			fault = F_CHECKSUM;
		else if (pick < 79)
			fault = F_SERVO;
		else if (pick < 85)
			fault = F_TIMEOUT;
		else if (pick < 90)
			fault = F_LINK;
		else if (pick < 95)
			fault = F_RESTART;
		else
			fault = F_GARBLE;
		send_reply(id, 1'($urandom_range(1)), pos, fault);
	endtask

	task automatic drain_replies();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_noise();
		send_idle_noise();
		send_idle_noise();
		send_reply(8'hFE, 1'b0, 16'h0000, F_NONE);
		send_reply(8'h00, 1'b1, 16'hFFFF, F_NONE);
		send_reply(8'h5A, 1'b1, 16'h1234, F_TIMEOUT);

		while (items_sent - ignored < 600)
			random_reply();
		drain_replies();

		calm = 1'b1;
		while (items_sent - ignored < 1000)
			random_reply();
		calm = 1'b0;
		drain_replies();

		while (items_sent - ignored < ITEM_TARGET)
			random_reply();
		drain_replies();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
